FILE: rtl/pls_pkg.sv
// package for the polyline splitter: constants, defaults and point role codes
package pls_pkg;

  localparam int MAX_SPLITS_DEF = 62;
  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic [31:0] SPLIT_LEN_RST = 32'd100000;
  localparam logic [33:0] RUN_MAX       = {34{1'b1}};

  typedef logic [1:0] role_t;

  localparam role_t ROLE_START    = 2'd0;
  localparam role_t ROLE_INTERIOR = 2'd1;
  localparam role_t ROLE_SPLIT    = 2'd2;
  localparam role_t ROLE_END      = 2'd3;

endpackage

FILE: rtl/polyline_split_by_length_top.sv
// polyline splitter: cuts a vertex stream into pieces of bounded arc length
//
// Input words carry one vertex (in_x_coord, in_y_coord, in_first_vertex,
// in_last_vertex), taken when in_valid is high and in_stall is low. Output
// words carry one point each (out_x, out_y, out_point_role,
// out_split_overflow, out_run_last), taken when out_valid is high and
// out_stall is low. cfg_we with cfg_wdata writes the split length.
// One vertex is handled at a time; in_stall is high while it is in work.
// A vertex that opens a line gives no output. An edge vertex goes through
// the multiplier for dx and dy squared, the square root, the overflow
// check, then per split point a compare, the divider, interpolation and
// output, and last the output of the vertex itself. The shared 32 by 32
// multiplier and the bit-serial root and divider do this work. A stalled
// receiver holds the output register and the sequencer waits on it.
// Synchronous reset clears the line state, empties the output and sets the
// split length to 100000.
module polyline_split_by_length_top #(
  parameter int MAX_SPLITS = pls_pkg::MAX_SPLITS_DEF,
  parameter int COORD_BITS = pls_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = pls_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_x_coord,
  input  logic signed [31:0] in_y_coord,
  input  logic               in_first_vertex,
  input  logic               in_last_vertex,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic [1:0]         out_point_role,
  output logic               out_split_overflow,
  output logic               out_run_last
);

  localparam int SH = 32 - COORD_BITS;
  localparam int FW = FRAC_BITS + 1;
  localparam logic [5:0] SQRT_LAST = 6'd32;
  localparam logic [5:0] K_MAX     = 6'(MAX_SPLITS);
  localparam logic [31:0] K_OVF    = 32'(MAX_SPLITS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MULX  = 4'd1;
  localparam logic [3:0] S_MULY  = 4'd2;
  localparam logic [3:0] S_SQRT  = 4'd3;
  localparam logic [3:0] S_OVF   = 4'd4;
  localparam logic [3:0] S_START = 4'd5;
  localparam logic [3:0] S_CHK   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_LERPX = 4'd8;
  localparam logic [3:0] S_LERPY = 4'd9;
  localparam logic [3:0] S_SPLIT = 4'd10;
  localparam logic [3:0] S_END   = 4'd11;

  logic [3:0]         state_r, state_nxt;
  logic [31:0]        len_r;
  logic signed [31:0] prev_x_r, prev_y_r, cur_x_r, cur_y_r;
  logic               last_r, have_prev_r, first_pend_r;
  logic [33:0]        run_r;
  logic signed [32:0] dx_r, dy_r;
  logic [65:0]        sq_r;
  logic [35:0]        rem_r;
  logic [32:0]        root_r;
  logic [5:0]         cnt_r;
  logic [32:0]        delta_r;
  logic [34:0]        total_r;
  logic               ovf_r;
  logic [5:0]         k_r;
  logic [37:0]        target_r;
  logic [FW-1:0]      quot_r;
  logic signed [31:0] lx_r, ly_r;
  logic               out_valid_r;
  logic signed [31:0] out_x_r, out_y_r;
  logic [1:0]         out_role_r;
  logic               out_ovf_r, out_last_r;

  logic [31:0]        len_eff;
  logic signed [31:0] sx_in, sy_in;
  logic [31:0]        mag_x, mag_y;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod;
  logic               out_free;
  logic [35:0]        rem_sh;
  logic [35:0]        trial;
  logic [37:0]        diff;
  logic [32:0]        numc;
  logic [35:0]        dsh;
  logic [31:0]        off;
  logic [37:0]        done_len;
  logic [37:0]        run_left;
  logic               accept;

  assign len_eff  = (len_r == 32'd0) ? 32'd1 : len_r;
  assign sx_in    = $signed(in_x_coord <<< SH) >>> SH;
  assign sy_in    = $signed(in_y_coord <<< SH) >>> SH;
  assign mag_x    = dx_r[32] ? 32'(-dx_r) : dx_r[31:0];
  assign mag_y    = dy_r[32] ? 32'(-dy_r) : dy_r[31:0];
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    case (state_r)
      S_MULX:  begin mul_a = mag_x;   mul_b = mag_x; end
      S_MULY:  begin mul_a = mag_y;   mul_b = mag_y; end
      S_OVF:   begin mul_a = len_eff; mul_b = K_OVF; end
      S_LERPX: begin mul_a = mag_x;   mul_b = 32'(quot_r); end
      S_LERPY: begin mul_a = mag_y;   mul_b = 32'(quot_r); end
      default: begin mul_a = 32'd0;   mul_b = 32'd0; end
    endcase
  end
  assign prod = mul_a * mul_b;
  assign off  = prod[FRAC_BITS +: 32];

  assign rem_sh = {rem_r[33:0], sq_r[65:64]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign diff   = (target_r > {4'd0, run_r}) ? target_r - {4'd0, run_r} : 38'd0;
  assign numc   = (diff > {5'd0, delta_r}) ? delta_r : diff[32:0];
  assign dsh    = {rem_r[34:0], 1'b0};
  assign done_len = target_r - {6'd0, len_eff};
  assign run_left = {3'd0, total_r} - done_len;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept && !in_first_vertex && have_prev_r) state_nxt = S_MULX;
      S_MULX:  state_nxt = S_MULY;
      S_MULY:  state_nxt = S_SQRT;
      S_SQRT:  if (cnt_r == SQRT_LAST) state_nxt = S_OVF;
      S_OVF:   state_nxt = first_pend_r ? S_START : S_CHK;
      S_START: if (out_free) state_nxt = S_CHK;
      S_CHK: begin
        if (k_r <= K_MAX && target_r <= {3'd0, total_r})
          state_nxt = (delta_r == 33'd0) ? S_LERPX : S_DIV;
        else
          state_nxt = S_END;
      end
      S_DIV:   if (cnt_r == 6'd1) state_nxt = S_LERPX;
      S_LERPX: state_nxt = S_LERPY;
      S_LERPY: state_nxt = S_SPLIT;
      S_SPLIT: if (out_free) state_nxt = S_CHK;
      S_END:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      len_r        <= pls_pkg::SPLIT_LEN_RST;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      run_r        <= '0;
      have_prev_r  <= 1'b0;
      first_pend_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) len_r <= cfg_wdata;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            cur_x_r <= sx_in;
            cur_y_r <= sy_in;
            last_r  <= in_last_vertex;
            dx_r    <= 33'(sx_in) - 33'(prev_x_r);
            dy_r    <= 33'(sy_in) - 33'(prev_y_r);
            if (in_first_vertex || !have_prev_r) begin
              prev_x_r     <= sx_in;
              prev_y_r     <= sy_in;
              run_r        <= '0;
              have_prev_r  <= !in_last_vertex;
              first_pend_r <= !in_last_vertex;
            end
          end
        end
        S_MULX: sq_r <= {2'd0, prod};
        S_MULY: begin
          sq_r   <= sq_r + {2'd0, prod};
          rem_r  <= '0;
          root_r <= '0;
          cnt_r  <= '0;
        end
        S_SQRT: begin
          sq_r  <= {sq_r[63:0], 2'd0};
          cnt_r <= cnt_r + 6'd1;
          if (rem_sh >= trial) begin
            rem_r  <= rem_sh - trial;
            root_r <= {root_r[31:0], 1'b1};
          end else begin
            rem_r  <= rem_sh;
            root_r <= {root_r[31:0], 1'b0};
          end
          if (cnt_r == SQRT_LAST) begin
            delta_r <= (rem_sh >= trial) ? {root_r[31:0], 1'b1} : {root_r[31:0], 1'b0};
            total_r <= {1'b0, run_r} + 35'((rem_sh >= trial) ? {root_r[31:0], 1'b1}
                                                             : {root_r[31:0], 1'b0});
          end
        end
        S_OVF: begin
          ovf_r    <= ({3'd0, total_r} >= prod[37:0]);
          k_r      <= 6'd1;
          target_r <= {6'd0, len_eff};
        end
        S_START: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_x_r      <= prev_x_r;
            out_y_r      <= prev_y_r;
            out_role_r   <= pls_pkg::ROLE_START;
            out_ovf_r    <= ovf_r;
            out_last_r   <= 1'b0;
            first_pend_r <= 1'b0;
          end
        end
        S_CHK: begin
          quot_r <= '0;
          if (numc >= delta_r && delta_r != 33'd0) begin
            quot_r[0] <= 1'b1;
            rem_r     <= '0;
          end else begin
            rem_r <= {3'd0, numc};
          end
          cnt_r <= 6'(FRAC_BITS);
        end
        S_DIV: begin
          cnt_r <= cnt_r - 6'd1;
          if (dsh >= {3'd0, delta_r}) begin
            rem_r  <= dsh - {3'd0, delta_r};
            quot_r <= {quot_r[FW-2:0], 1'b1};
          end else begin
            rem_r  <= dsh;
            quot_r <= {quot_r[FW-2:0], 1'b0};
          end
        end
        S_LERPX: lx_r <= dx_r[32] ? prev_x_r - $signed(off) : prev_x_r + $signed(off);
        S_LERPY: ly_r <= dy_r[32] ? prev_y_r - $signed(off) : prev_y_r + $signed(off);
        S_SPLIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_x_r     <= lx_r;
            out_y_r     <= ly_r;
            out_role_r  <= pls_pkg::ROLE_SPLIT;
            out_ovf_r   <= ovf_r;
            out_last_r  <= 1'b0;
            k_r         <= k_r + 6'd1;
            target_r    <= target_r + {6'd0, len_eff};
          end
        end
        S_END: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_x_r     <= cur_x_r;
            out_y_r     <= cur_y_r;
            out_role_r  <= last_r ? pls_pkg::ROLE_END : pls_pkg::ROLE_INTERIOR;
            out_ovf_r   <= ovf_r;
            out_last_r  <= 1'b1;
            prev_x_r    <= cur_x_r;
            prev_y_r    <= cur_y_r;
            if (last_r) begin
              run_r        <= '0;
              have_prev_r  <= 1'b0;
              first_pend_r <= 1'b0;
            end else begin
              run_r <= (run_left > {4'd0, pls_pkg::RUN_MAX}) ? pls_pkg::RUN_MAX
                                                           : run_left[33:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_x              = out_x_r;
  assign out_y              = out_y_r;
  assign out_point_role     = out_role_r;
  assign out_split_overflow = out_ovf_r;
  assign out_run_last       = out_last_r;

`ifndef NO_ASSERTIONS
  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_r != S_MULX && state_r != S_MULY && state_r != S_SQRT &&
     state_r != S_OVF)
      |-> (k_r <= K_MAX + 6'd1))
    else $error("split counter ran past its limit");
  a_split_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_last_r && out_role_r == pls_pkg::ROLE_SPLIT))
    else $error("split point flagged as last word");
  a_start_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_START) |-> first_pend_r)
    else $error("start point without pending first vertex");
  a_emit_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_END && out_valid_r && out_stall) |=> (state_r == S_END))
    else $error("end point left while output blocked");
`endif

endmodule

FILE: sim/polyline_split_by_length_top_test.sv
// testbench for the polyline splitter: random and directed vertex streams checked by a predictor
`timescale 1ns / 100ps

module polyline_split_by_length_top_test;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               first;
    logic               last;
    logic [31:0]        cfg;
    logic               do_cfg;
  } vtx_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    pls_pkg::role_t     role;
    logic               ovf;
    logic               rlast;
  } pt_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_x_coord = '0;
  logic signed [31:0] in_y_coord = '0;
  logic in_first_vertex = 1'b0;
  logic in_last_vertex = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic [1:0] out_point_role;
  logic out_split_overflow;
  logic out_run_last;

  polyline_split_by_length_top dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_x_coord(in_x_coord),
    .in_y_coord(in_y_coord), .in_first_vertex(in_first_vertex),
    .in_last_vertex(in_last_vertex), .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .out_point_role(out_point_role),
    .out_split_overflow(out_split_overflow), .out_run_last(out_run_last)
  );

  always #6 clk = ~clk;

  vtx_t pending[$];
  pt_t  points_due[$];
  int   errors = 0;
  int   words_sent = 0;
  int   points_seen = 0;
  int   splits_seen = 0;
  int   ovf_seen = 0;
  bit   stim_done = 1'b0;
  bit   hold_rx = 1'b0;
  bit   in_taken = 1'b0;

  // predictor state
  logic signed [31:0] last_x = '0;
  logic signed [31:0] last_y = '0;
  logic [33:0] run_len = '0;
  bit line_open = 1'b0;
  bit start_due = 1'b0;
  logic [31:0] seg_len = pls_pkg::SPLIT_LEN_RST;

  function automatic logic [63:0] floor_root(logic [65:0] v);
    logic [65:0] rem;
    logic [65:0] trial;
    logic [63:0] root;
    rem = '0;
    root = '0;
    for (int i = 32; i >= 0; i--) begin
      rem = (rem << 2) | ((v >> (2 * i)) & 66'd3);
      trial = {root, 2'b01};
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic logic signed [31:0] interp(logic signed [63:0] p,
                                                logic signed [63:0] d, logic [63:0] f);
    logic [63:0] m;
    logic [127:0] off;
    m = d < 0 ? -d : d;
    off = ({64'd0, m} * {64'd0, f}) >> pls_pkg::FRAC_BITS_DEF;
    return d < 0 ? 32'(p - $signed(off[63:0])) : 32'(p + $signed(off[63:0]));
  endfunction

  task automatic predict_vertex(vtx_t v);
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    logic [63:0] ax;
    logic [63:0] ay;
    logic [65:0] sq;
    logic [63:0] delta;
    logic [63:0] total;
    logic [63:0] len;
    logic [63:0] n;
    logic [63:0] num;
    logic [63:0] f;
    logic ovf;
    pt_t p;
    if (v.first || !line_open) begin
      last_x = v.x;
      last_y = v.y;
      run_len = '0;
      line_open = !v.last;
      start_due = !v.last;
      return;
    end
    dx = 64'(v.x) - 64'(last_x);
    dy = 64'(v.y) - 64'(last_y);
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    sq = 66'(ax * ax) + 66'(ay * ay);
    delta = floor_root(sq);
    len = seg_len == 0 ? 64'd1 : 64'(seg_len);
    total = 64'(run_len) + delta;
    n = total / len;
    ovf = 1'b0;
    if (n > 64'(pls_pkg::MAX_SPLITS_DEF)) begin
      n = 64'(pls_pkg::MAX_SPLITS_DEF);
      ovf = 1'b1;
    end
    if (start_due) begin
      p = '{last_x, last_y, pls_pkg::ROLE_START, ovf, 1'b0};
      points_due = {points_due, p};
      start_due = 1'b0;
    end
    for (longint k = 1; k <= n; k++) begin
      num = k * len > 64'(run_len) ? k * len - 64'(run_len) : 64'd0;
      f = 64'd0;
      if (delta != 0) begin
        if (num > delta) num = delta;
        f = (num << pls_pkg::FRAC_BITS_DEF) / delta;
      end
      p = '{interp(last_x, dx, f), interp(last_y, dy, f), pls_pkg::ROLE_SPLIT, ovf, 1'b0};
      points_due = {points_due, p};
    end
    p = '{v.x, v.y, v.last ? pls_pkg::ROLE_END : pls_pkg::ROLE_INTERIOR, ovf, 1'b1};
    points_due = {points_due, p};
    total = total - n * len;
    run_len = total > 64'(pls_pkg::RUN_MAX) ? pls_pkg::RUN_MAX : total[33:0];
    last_x = v.x;
    last_y = v.y;
    if (v.last) begin
      line_open = 1'b0;
      start_due = 1'b0;
      run_len = '0;
    end
  endtask

  function automatic int short_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
  endfunction

  // input handshake seen at the rising edge
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
  end

  // driver: one word per handshake, config words applied only when idle
  int tx_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      cfg_we <= 1'b0;
      if (in_taken) begin
        predict_vertex(pending.pop_front());
        words_sent++;
        tx_gap = ($urandom_range(0, 3) == 0) ? short_gap() : 0;
      end
      if (in_valid && !in_taken) begin
      end else if (tx_gap > 0) begin
        in_valid <= 1'b0;
        tx_gap--;
      end else if (pending.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending[0].do_cfg) begin
        in_valid <= 1'b0;
        if (points_due.size() == 0) begin
          if (tx_gap == 0 && pending[0].first) begin
            cfg_we <= 1'b1;
            cfg_wdata <= pending[0].cfg;
            seg_len = pending[0].cfg;
            void'(pending.pop_front());
          end else begin
            pending[0].first = 1'b1;
            tx_gap = 2000;
          end
        end
      end else begin
        in_valid <= 1'b1;
        in_x_coord <= pending[0].x;
        in_y_coord <= pending[0].y;
        in_first_vertex <= pending[0].first;
        in_last_vertex <= pending[0].last;
      end
    end
  end

  // receiver stall pattern
  int rx_gap = 0;
  always @(negedge clk) begin
    if (hold_rx) begin
      out_stall <= 1'b1;
    end else if (rx_gap > 0) begin
      out_stall <= 1'b1;
      rx_gap--;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 4) == 0) rx_gap = short_gap();
    end
  end

  // monitor
  always @(posedge clk) begin
    pt_t e;
    if (rst_n && out_valid && !out_stall) begin
      points_seen++;
      if (points_due.size() == 0) begin
        $error("unexpected word x=%0d y=%0d", out_x, out_y);
        errors++;
      end else begin
        e = points_due.pop_front();
        if (out_x !== e.x) begin
          $error("out_x expected %0d got %0d", e.x, out_x); errors++;
        end
        if (out_y !== e.y) begin
          $error("out_y expected %0d got %0d", e.y, out_y); errors++;
        end
        if (out_point_role !== e.role) begin
          $error("out_point_role expected %0d got %0d", e.role, out_point_role); errors++;
        end
        if (out_split_overflow !== e.ovf) begin
          $error("out_split_overflow expected %0d got %0d", e.ovf, out_split_overflow);
          errors++;
        end
        if (out_run_last !== e.rlast) begin
          $error("out_run_last expected %0d got %0d", e.rlast, out_run_last); errors++;
        end
        if (e.role == pls_pkg::ROLE_SPLIT) splits_seen++;
        if (e.ovf) ovf_seen++;
      end
    end
  end

  function automatic vtx_t mk(int x, int y, bit f, bit l);
    vtx_t v;
    v = '{x, y, f, l, 32'd0, 1'b0};
    return v;
  endfunction

  function automatic vtx_t mkcfg(logic [31:0] c);
    vtx_t v;
    v = '{0, 0, 1'b0, 1'b0, c, 1'b1};
    return v;
  endfunction

  function automatic int rnd_coord(int span);
    return $urandom_range(0, 3) == 0 ? int'($urandom) : int'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic add_line(int nv, int span);
    int x;
    int y;
    x = rnd_coord(span);
    y = rnd_coord(span);
    for (int i = 0; i < nv; i++) begin
      pending = {pending, mk(x, y, i == 0, i == nv - 1)};
      x = x + int'($urandom_range(0, 2 * span)) - span;
      y = y + int'($urandom_range(0, 2 * span)) - span;
    end
  endtask

  initial begin
    // directed
    pending = {pending, mk(32'sh7fffffff, 32'sh80000000, 1'b1, 1'b1)};
    pending = {pending, mk(5, 5, 1'b0, 1'b0)};
    pending = {pending, mk(5, 5, 1'b0, 1'b0)};
    pending = {pending, mk(150000, 5, 1'b0, 1'b0)};
    pending = {pending, mk(1, 2, 1'b1, 1'b0)};
    pending = {pending, mk(-1, -2, 1'b0, 1'b1)};
    pending = {pending, mkcfg(32'd0)};
    pending = {pending, mk(0, 0, 1'b1, 1'b0)};
    pending = {pending, mk(0, 0, 1'b0, 1'b0)};
    pending = {pending, mk(10, -7, 1'b0, 1'b0)};
    pending = {pending, mk(32'sh80000000, 32'sh7fffffff, 1'b0, 1'b0)};
    pending = {pending, mk(32'sh7fffffff, 32'sh80000000, 1'b0, 1'b1)};
    pending = {pending, mkcfg(32'hffffffff)};
    pending = {pending, mk(32'sh80000000, 32'sh80000000, 1'b1, 1'b0)};
    pending = {pending, mk(32'sh7fffffff, 32'sh7fffffff, 1'b0, 1'b1)};
    pending = {pending, mkcfg(32'd3)};
    pending = {pending, mk(0, 0, 1'b1, 1'b0)};
    pending = {pending, mk(100, 0, 1'b0, 1'b0)};
    pending = {pending, mk(100, 40, 1'b0, 1'b1)};
    // random
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: pending = {pending, mkcfg(32'd1000)};
        1: pending = {pending, mkcfg(32'd1)};
        2: pending = {pending, mkcfg($urandom)};
        3: pending = {pending, mkcfg(32'd250)};
        4: pending = {pending, mkcfg(32'd100000)};
        default: pending = {pending, mkcfg(32'd40)};
      endcase
      for (int ln = 0; ln < 10; ln++) begin
        if ($urandom_range(0, 7) == 0)
          pending = {pending, mk(int'($urandom), int'($urandom), $urandom_range(0, 1),
                                 $urandom_range(0, 1))};
        else
          add_line($urandom_range(2, 7), ph == 1 ? 20 : 3000);
      end
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // long receiver hold while the sender keeps going
  initial begin
    @(posedge rst_n);
    wait (words_sent >= 60);
    hold_rx = 1'b1;
    repeat (3000) @(posedge clk);
    hold_rx = 1'b0;
  end

  initial begin
    @(posedge rst_n);
    wait (pending.size() == 0 && !in_valid);
    wait (points_due.size() == 0);
    repeat (400) @(posedge clk);
    $display("%0d vertices sent, %0d points checked, %0d split points, %0d overflow points",
             words_sent, points_seen, splits_seen, ovf_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/pls_pkg.sv
rtl/polyline_split_by_length_top.sv
sim/polyline_split_by_length_top_test.sv
